[hw/rtl/tracker_module_header_sizer_assert.svh]
// Assertion macros for the tracker module header sizer checker.
// Depends on signals named clk and rst_n in the scope that uses them.
`ifndef TRACKER_MODULE_HEADER_SIZER_ASSERT_SVH
`define TRACKER_MODULE_HEADER_SIZER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TMHS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define TMHS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tmhs_pkg.sv]
// Shared types and constants for the tracker module header sizer.
// No dependencies.
package tmhs_pkg;

    localparam logic [10:0] HDR_LEN    = 11'd1084;
    localparam logic [10:0] SMP_FIRST  = 11'h02a;
    localparam logic [10:0] SMP_LAST   = 11'h3af;
    localparam logic [10:0] SONG_OFF   = 11'h3b6;
    localparam logic [10:0] ORD_OFF    = 11'h3b8;
    localparam logic [10:0] ORD_LAST   = 11'h437;
    localparam logic [10:0] TAG_OFF    = 11'h438;
    localparam logic [10:0] TAG_LAST   = 11'h43b;

    // offset mod 30 of the high and low byte of each sample length word
    localparam logic [4:0]  SMP_STRIDE_LAST = 5'd29;
    localparam logic [4:0]  SMP_PHASE_HIGH  = 5'd12;
    localparam logic [4:0]  SMP_PHASE_LOW   = 5'd13;

    localparam logic [7:0]  TOP_LIMIT  = 8'd127;
    localparam logic [22:0] HDR_SPAN   = 23'h43b;
    localparam logic [24:0] MAX_LEN_RESET = 25'd1048576;

    localparam int unsigned NUM_TAGS = 8;
    localparam logic [31:0] TAG_IDS [NUM_TAGS] = '{
        32'h4D2E4B2E, 32'h4D214B21, 32'h3443484E, 32'h3643484E,
        32'h3843484E, 32'h464C5434, 32'h464C5438, 32'h4D264B21
    };
    localparam logic [3:0]  TAG_CHANS [NUM_TAGS] = '{
        4'd4, 4'd4, 4'd4, 4'd6, 4'd8, 4'd4, 4'd8, 4'd4
    };

    typedef enum logic [2:0] {
        STATUS_OK,
        STATUS_NO_TAG,
        STATUS_SAMPLES_LONG,
        STATUS_BAD_SONG_LEN,
        STATUS_PATTERN_RANGE,
        STATUS_PATTERNS_LONG,
        STATUS_MODULE_LONG
    } status_t;

    // header summary handed from front to back
    typedef struct packed {
        logic        found;
        logic [2:0]  fmt;
        logic [3:0]  chans;
        logic [21:0] sample_sum;
        logic [7:0]  song_len;
        logic [7:0]  top_pat;
        logic [23:0] start;
    } hdr_rec_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  fmt;
        logic [3:0]  chans;
        logic [21:0] sample_bytes;
        logic [7:0]  order_length;
        logic [7:0]  top_pattern;
        logic [23:0] module_start;
        logic [24:0] module_end;
    } result_t;

endpackage

[hw/rtl/tracker_module_header_sizer.sv]
// Tracker module header sizer: takes one header byte per cycle while not full.
// The result reaches the output ports after the byte at offset 0x43b is
// accepted, registered in the header queue and, after the length checks, in
// the result queue; a new 1084-byte header can start while results wait.
// Reset clears all accumulators, both queues and sets the length limit to
// 1048576; after reset a header starts at offset zero with start address 0.
module tracker_module_header_sizer #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  header_byte,
    input  logic        first_byte,
    input  logic [23:0] base_address,
    input  logic        cfg_write_en,
    input  logic [24:0] cfg_write_data,
    input  logic        pop,
    output logic        empty,
    output logic [2:0]  status,
    output logic [2:0]  format_index,
    output logic [3:0]  channel_count,
    output logic [21:0] sample_bytes,
    output logic [7:0]  order_length,
    output logic [7:0]  top_pattern,
    output logic [23:0] module_start,
    output logic [24:0] module_end
);
    import tmhs_pkg::*;

    logic [24:0] max_len_reg;
    logic        rec_valid, rec_full, rec_empty, rec_pop;
    hdr_rec_t    rec_in, rec_head;
    logic        res_push, res_full;
    result_t     res_in, res_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_LEN_RESET;
        else if (cfg_write_en)
            max_len_reg <= cfg_write_data;
    end

    tmhs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .header_byte  (header_byte),
        .first_byte   (first_byte),
        .base_address (base_address),
        .rec_valid    (rec_valid),
        .rec          (rec_in),
        .rec_full     (rec_full)
    );

    tmhs_fifo #(.item_t(hdr_rec_t), .DEPTH(QUEUE_DEPTH)) u_rec_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rec_valid),
        .wdata (rec_in),
        .full  (rec_full),
        .pop   (rec_pop),
        .rdata (rec_head),
        .empty (rec_empty)
    );

    tmhs_back u_back (
        .rec_empty (rec_empty),
        .rec       (rec_head),
        .rec_pop   (rec_pop),
        .max_len   (max_len_reg),
        .res_push  (res_push),
        .res       (res_in),
        .res_full  (res_full)
    );

    tmhs_fifo #(.item_t(result_t), .DEPTH(QUEUE_DEPTH)) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_head),
        .empty (empty)
    );

    assign status        = res_head.status;
    assign format_index  = res_head.fmt;
    assign channel_count = res_head.chans;
    assign sample_bytes  = res_head.sample_bytes;
    assign order_length  = res_head.order_length;
    assign top_pattern   = res_head.top_pattern;
    assign module_start  = res_head.module_start;
    assign module_end    = res_head.module_end;

endmodule

[hw/rtl/tmhs_fifo.sv]
// Small first-in first-out queue of any packed type.
// No package dependency.
module tmhs_fifo #(
    parameter type item_t = logic,
    parameter int unsigned DEPTH = 2
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wdata,
    output logic  full,
    input  logic  pop,
    output item_t rdata,
    output logic  empty
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    item_t             mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[hw/rtl/tmhs_front.sv]
// Front end: takes header bytes one per cycle while rec_full is low, keeps
// running accumulators and matches the tag. Depends on tmhs_pkg.
module tmhs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        header_byte,
    input  logic              first_byte,
    input  logic [23:0]       base_address,
    output logic              rec_valid,
    output tmhs_pkg::hdr_rec_t rec,
    input  logic              rec_full
);
    import tmhs_pkg::*;

    logic [10:0] offset_reg, offset_next, off_eff;
    logic [4:0]  phase_reg, phase_next, phase_eff;
    logic [21:0] sum_reg, sum_next, sum_eff;
    logic [7:0]  len_hi_reg, len_hi_next, len_hi_eff;
    logic [7:0]  song_reg, song_next, song_eff;
    logic [7:0]  top_reg, top_next, top_eff;
    logic [23:0] tag_reg, tag_next, tag_eff;
    logic [23:0] start_reg, start_next, start_eff;
    logic        accept, active;
    logic [6:0]  ord_idx;
    logic [31:0] tag_word;
    logic        found;
    logic [2:0]  fmt;
    logic [3:0]  chans;

    assign full   = rec_full;
    assign accept = push && !rec_full;

    // a first byte clears the header before it is processed
    assign off_eff    = first_byte ? '0 : offset_reg;
    assign phase_eff  = first_byte ? '0 : phase_reg;
    assign sum_eff    = first_byte ? '0 : sum_reg;
    assign len_hi_eff = first_byte ? '0 : len_hi_reg;
    assign song_eff   = first_byte ? '0 : song_reg;
    assign top_eff    = first_byte ? '0 : top_reg;
    assign tag_eff    = first_byte ? '0 : tag_reg;
    assign start_eff  = first_byte ? base_address : start_reg;

    assign active   = accept && (off_eff != HDR_LEN);
    assign ord_idx  = 7'(off_eff - ORD_OFF);
    assign tag_word = {tag_eff, header_byte};

    always_comb
    begin
        found = 1'b0;
        fmt   = '0;
        chans = '0;
        // descending scan so the first table entry wins
        for (int t = NUM_TAGS - 1; t >= 0; t--)
        begin
            if (tag_word == TAG_IDS[t])
            begin
                found = 1'b1;
                fmt   = 3'(t);
                chans = TAG_CHANS[t];
            end
        end
    end

    always_comb
    begin
        offset_next = offset_reg;
        phase_next  = phase_reg;
        sum_next    = sum_reg;
        len_hi_next = len_hi_reg;
        song_next   = song_reg;
        top_next    = top_reg;
        tag_next    = tag_reg;
        start_next  = start_reg;
        if (accept)
        begin
            offset_next = off_eff;
            phase_next  = phase_eff;
            sum_next    = sum_eff;
            len_hi_next = len_hi_eff;
            song_next   = song_eff;
            top_next    = top_eff;
            tag_next    = tag_eff;
            start_next  = start_eff;
        end
        if (active)
        begin
            offset_next = off_eff + 1'b1;
            phase_next  = (phase_eff == SMP_STRIDE_LAST) ? '0 : phase_eff + 1'b1;
            if (off_eff >= SMP_FIRST && off_eff <= SMP_LAST)
            begin
                if (phase_eff == SMP_PHASE_HIGH)
                begin
                    len_hi_next = header_byte;
                end
                else if (phase_eff == SMP_PHASE_LOW)
                begin
                    sum_next = sum_eff + 22'({len_hi_eff, header_byte, 1'b0});
                end
            end
            if (off_eff == SONG_OFF)
            begin
                song_next = header_byte;
            end
            if (off_eff >= ORD_OFF && off_eff <= ORD_LAST
                && {1'b0, ord_idx} < song_eff && header_byte > top_eff)
            begin
                top_next = header_byte;
            end
            if (off_eff >= TAG_OFF && off_eff < TAG_LAST)
            begin
                tag_next = {tag_eff[15:0], header_byte};
            end
        end
    end

    assign rec_valid      = active && (off_eff == TAG_LAST);
    assign rec.found      = found;
    assign rec.fmt        = fmt;
    assign rec.chans      = chans;
    assign rec.sample_sum = sum_eff;
    assign rec.song_len   = song_eff;
    assign rec.top_pat    = top_eff;
    assign rec.start      = start_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            phase_reg  <= '0;
            sum_reg    <= '0;
            len_hi_reg <= '0;
            song_reg   <= '0;
            top_reg    <= '0;
            tag_reg    <= '0;
            start_reg  <= '0;
        end
        else
        begin
            offset_reg <= offset_next;
            phase_reg  <= phase_next;
            sum_reg    <= sum_next;
            len_hi_reg <= len_hi_next;
            song_reg   <= song_next;
            top_reg    <= top_next;
            tag_reg    <= tag_next;
            start_reg  <= start_next;
        end
    end

endmodule

[hw/rtl/tmhs_back.sv]
// Back end: sizes the patterns, runs the length checks and forms the result.
// Depends on tmhs_pkg.
module tmhs_back (
    input  logic                 rec_empty,
    input  tmhs_pkg::hdr_rec_t   rec,
    output logic                 rec_pop,
    input  logic [24:0]          max_len,
    output logic                 res_push,
    output tmhs_pkg::result_t    res,
    input  logic                 res_full
);
    import tmhs_pkg::*;

    logic [8:0]  pat_rows;
    logic [12:0] pat_units;
    logic [20:0] pat_bytes;
    logic [22:0] total;
    status_t     status;

    assign rec_pop  = !rec_empty && !res_full;
    assign res_push = rec_pop;

    assign pat_rows  = {1'b0, rec.top_pat} + 9'd1;
    assign pat_units = 13'(pat_rows) * 13'(rec.chans);
    assign pat_bytes = {pat_units, 8'h00};
    assign total     = 23'(rec.sample_sum) + 23'(pat_bytes) + HDR_SPAN;

    always_comb
    begin
        if (!rec.found)
            status = STATUS_NO_TAG;
        else if (25'(rec.sample_sum) > max_len)
            status = STATUS_SAMPLES_LONG;
        else if (rec.song_len == '0 || 25'(rec.song_len) > max_len)
            status = STATUS_BAD_SONG_LEN;
        else if (rec.top_pat > TOP_LIMIT)
            status = STATUS_PATTERN_RANGE;
        else if (25'(pat_bytes) > max_len)
            status = STATUS_PATTERNS_LONG;
        else if (25'(total) >= max_len)
            status = STATUS_MODULE_LONG;
        else
            status = STATUS_OK;
    end

    assign res.status       = status;
    assign res.fmt          = rec.fmt;
    assign res.chans        = rec.chans;
    assign res.sample_bytes = rec.sample_sum;
    assign res.order_length = rec.song_len;
    assign res.top_pattern  = rec.top_pat;
    assign res.module_start = rec.start;
    assign res.module_end   = (status == STATUS_OK || status == STATUS_MODULE_LONG)
                              ? 25'(rec.start) + 25'(total) : '0;

endmodule

[hw/rtl/tmhs_checker.sv]
// Port-level checks for the tracker module header sizer, bound to the top.
// Depends on tmhs_pkg and tracker_module_header_sizer_assert.svh.
`include "tracker_module_header_sizer_assert.svh"

module tmhs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pop,
    input logic        empty,
    input logic [2:0]  status,
    input logic [2:0]  format_index,
    input logic [3:0]  channel_count,
    input logic [24:0] module_end
);
    import tmhs_pkg::*;

    // end address is only reported for a clean or an overlong module
    `TMHS_ASSERT_NOW(a_end_zero, !empty && status != STATUS_OK && status != STATUS_MODULE_LONG, module_end == '0, "module_end set on failed header")
    // no tag means no format and no channels
    `TMHS_ASSERT_NOW(a_no_tag, !empty && status == STATUS_NO_TAG, channel_count == '0 && format_index == '0, "format reported without tag")
    // any matched tag carries 4, 6 or 8 channels
    `TMHS_ASSERT_NOW(a_chans, !empty && status != STATUS_NO_TAG, channel_count == 4'd4 || channel_count == 4'd6 || channel_count == 4'd8, "bad channel count")
    // a waiting result stays until taken
    `TMHS_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(status) && $stable(module_end), "result changed while waiting")

endmodule

bind tracker_module_header_sizer tmhs_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop           (pop),
    .empty         (empty),
    .status        (status),
    .format_index  (format_index),
    .channel_count (channel_count),
    .module_end    (module_end)
);
